### rtl/dda_pkg.sv
`default_nettype none

package dda_pkg;

	localparam int COORD_BITS_DEF = 11;
	localparam int FRAC_BITS_DEF  = 16;

	// entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_NEXT  = 1'b1;

	typedef enum logic {
		BK_IDLE,
		BK_DIV
	} back_state_t;

endpackage

`default_nettype wire

### rtl/dda_front.sv
`default_nettype none

module dda_front #(
	parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         func,
	input  wire logic signed [COORD_BITS-1:0] x_start,
	input  wire logic signed [COORD_BITS-1:0] y_start,
	input  wire logic signed [COORD_BITS-1:0] x_end,
	input  wire logic signed [COORD_BITS-1:0] y_end,
	output logic                              q_valid,
	input  wire logic                         q_pop,
	output logic                              q_func,
	output logic signed [COORD_BITS-1:0]      q_xa,
	output logic signed [COORD_BITS-1:0]      q_ya,
	output logic [COORD_BITS-1:0]             q_adx,
	output logic [COORD_BITS-1:0]             q_ady,
	output logic                              q_sx,
	output logic                              q_sy,
	output logic [COORD_BITS-1:0]             q_steps
);

	localparam int C  = COORD_BITS;
	localparam int QD = dda_pkg::QUEUE_DEPTH;
	localparam int PW = (QD > 1) ? $clog2(QD) : 1;
	localparam int NW = $clog2(QD + 1);
	localparam int EW = 5 * C + 3;

	logic signed [C:0] dx;
	logic signed [C:0] dy;
	logic [C-1:0]      adx;
	logic [C-1:0]      ady;
	logic [C-1:0]      steps;
	logic [EW-1:0]     entry;
	logic [EW-1:0]     head;
	logic              push;

	logic [EW-1:0] mem_q [QD];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;

	always_comb begin
		dx    = {x_end[C-1], x_end} - {x_start[C-1], x_start};
		dy    = {y_end[C-1], y_end} - {y_start[C-1], y_start};
		// |delta| < 2^C, so the magnitude fits in C bits
		adx   = dx[C] ? C'(~dx[C-1:0] + 1'b1) : dx[C-1:0];
		ady   = dy[C] ? C'(~dy[C-1:0] + 1'b1) : dy[C-1:0];
		steps = (adx > ady) ? adx : ady;
		entry = {func, x_start, y_start, adx, ady, dx[C], dy[C], steps};
	end

	assign in_ready = (count_q != NW'(QD));
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];
	assign {q_func, q_xa, q_ya, q_adx, q_ady, q_sx, q_sy, q_steps} = head;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QD - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QD - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/dda_back.sv
`default_nettype none

module dda_back #(
	parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_valid,
	output logic                              q_pop,
	input  wire logic                         q_func,
	input  wire logic signed [COORD_BITS-1:0] q_xa,
	input  wire logic signed [COORD_BITS-1:0] q_ya,
	input  wire logic [COORD_BITS-1:0]        q_adx,
	input  wire logic [COORD_BITS-1:0]        q_ady,
	input  wire logic                         q_sx,
	input  wire logic                         q_sy,
	input  wire logic [COORD_BITS-1:0]        q_steps,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [COORD_BITS-1:0]      point_x,
	output logic signed [COORD_BITS-1:0]      point_y,
	output logic                              point_valid,
	output logic                              point_last
);

	localparam int C  = COORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int AW = C + F + 1;
	localparam int SW = F + 2;
	localparam int NW = $clog2(F);
	localparam logic signed [AW-1:0] HALF = {{(AW - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};

	dda_pkg::back_state_t state_q;
	dda_pkg::back_state_t state_d;

	logic [NW-1:0]        cnt_q;
	logic                 line_active_q;
	logic                 out_valid_q;
	logic                 slot_free;
	logic                 is_start;

	logic signed [AW-1:0] x_accum_q;
	logic signed [AW-1:0] y_accum_q;
	logic signed [SW-1:0] x_step_q;
	logic signed [SW-1:0] y_step_q;
	logic [C-1:0]         steps_left_q;
	logic [C-1:0]         steps_dec;

	logic [C-1:0]         div_q;
	logic [C-1:0]         x_rem_q;
	logic [C-1:0]         y_rem_q;
	logic [F:0]           x_quo_q;
	logic [F:0]           y_quo_q;
	logic                 x_neg_q;
	logic                 y_neg_q;

	logic [C:0]           x_rem2;
	logic [C:0]           y_rem2;
	logic                 x_ge;
	logic                 y_ge;
	logic [C:0]           x_rem_d;
	logic [C:0]           y_rem_d;
	logic [F:0]           x_quo;
	logic [F:0]           y_quo;
	logic signed [SW-1:0] x_inc;
	logic signed [SW-1:0] y_inc;

	logic signed [AW-1:0] x_sum;
	logic signed [AW-1:0] y_sum;
	logic signed [AW-1:0] x_half;
	logic signed [AW-1:0] y_half;
	logic [C-1:0]         x_pt;
	logic [C-1:0]         y_pt;

	logic signed [C-1:0]  point_x_q;
	logic signed [C-1:0]  point_y_q;
	logic                 point_valid_q;
	logic                 point_last_q;

	always_comb begin
		slot_free = !out_valid_q || out_ready;
		is_start  = (q_func == dda_pkg::FUNC_START);
		state_d   = state_q;
		q_pop     = 1'b0;
		case (state_q)
			dda_pkg::BK_IDLE: begin
				if (q_valid && slot_free) begin
					q_pop = 1'b1;
					if (is_start && q_steps != '0) begin
						state_d = dda_pkg::BK_DIV;
					end
				end
			end
			dda_pkg::BK_DIV: begin
				if (cnt_q == NW'(F - 1)) begin
					state_d = dda_pkg::BK_IDLE;
				end
			end
			default: state_d = dda_pkg::BK_IDLE;
		endcase
	end

	// restoring divide, one quotient bit per cycle for both axes
	always_comb begin
		x_rem2  = {x_rem_q, 1'b0};
		y_rem2  = {y_rem_q, 1'b0};
		x_ge    = (x_rem2 >= {1'b0, div_q});
		y_ge    = (y_rem2 >= {1'b0, div_q});
		x_rem_d = x_ge ? (x_rem2 - {1'b0, div_q}) : x_rem2;
		y_rem_d = y_ge ? (y_rem2 - {1'b0, div_q}) : y_rem2;
		x_quo   = {x_quo_q[F-1:0], x_ge};
		y_quo   = {y_quo_q[F-1:0], y_ge};
		x_inc   = x_neg_q ? -$signed({1'b0, x_quo}) : $signed({1'b0, x_quo});
		y_inc   = y_neg_q ? -$signed({1'b0, y_quo}) : $signed({1'b0, y_quo});
	end

	// accumulate, then add one half and truncate toward zero
	always_comb begin
		x_sum     = x_accum_q + {{(AW - SW){x_step_q[SW-1]}}, x_step_q};
		y_sum     = y_accum_q + {{(AW - SW){y_step_q[SW-1]}}, y_step_q};
		x_half    = x_sum + HALF;
		y_half    = y_sum + HALF;
		x_pt      = x_half[F+C-1:F] + {{(C - 1){1'b0}}, x_half[AW-1] & (|x_half[F-1:0])};
		y_pt      = y_half[F+C-1:F] + {{(C - 1){1'b0}}, y_half[AW-1] & (|y_half[F-1:0])};
		steps_dec = steps_left_q - 1'b1;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			if (is_start) begin
				x_accum_q     <= {q_xa[C-1], q_xa, {F{1'b0}}};
				y_accum_q     <= {q_ya[C-1], q_ya, {F{1'b0}}};
				steps_left_q  <= q_steps;
				div_q         <= q_steps;
				// a delta equal to steps gives the integer quotient bit
				x_rem_q       <= (q_adx == q_steps) ? '0 : q_adx;
				y_rem_q       <= (q_ady == q_steps) ? '0 : q_ady;
				x_quo_q       <= {{F{1'b0}}, q_adx == q_steps};
				y_quo_q       <= {{F{1'b0}}, q_ady == q_steps};
				x_neg_q       <= q_sx;
				y_neg_q       <= q_sy;
				point_x_q     <= q_xa;
				point_y_q     <= q_ya;
				point_valid_q <= 1'b1;
				point_last_q  <= (q_steps == '0);
			end else if (line_active_q) begin
				x_accum_q     <= x_sum;
				y_accum_q     <= y_sum;
				steps_left_q  <= steps_dec;
				point_x_q     <= x_pt;
				point_y_q     <= y_pt;
				point_valid_q <= 1'b1;
				point_last_q  <= (steps_dec == '0);
			end else begin
				point_x_q     <= '0;
				point_y_q     <= '0;
				point_valid_q <= 1'b0;
				point_last_q  <= 1'b0;
			end
		end
		if (state_q == dda_pkg::BK_DIV) begin
			x_rem_q <= x_rem_d[C-1:0];
			y_rem_q <= y_rem_d[C-1:0];
			x_quo_q <= x_quo;
			y_quo_q <= y_quo;
			if (cnt_q == NW'(F - 1)) begin
				x_step_q <= x_inc;
				y_step_q <= y_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= dda_pkg::BK_IDLE;
			cnt_q         <= '0;
			line_active_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				cnt_q <= '0;
			end else if (state_q == dda_pkg::BK_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (q_pop) begin
				if (is_start) begin
					line_active_q <= (q_steps != '0);
				end else if (line_active_q && steps_dec == '0) begin
					line_active_q <= 1'b0;
				end
			end
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign point_x     = point_x_q;
	assign point_y     = point_y_q;
	assign point_valid = point_valid_q;
	assign point_last  = point_last_q;

endmodule

`default_nettype wire

### rtl/dda_line_rasterizer.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   func, x_start, y_start, x_end, y_end
// output    out        out_valid / out_ready point_x, point_y, point_valid, point_last
//
// A next item or a zero-length start is taken straight from the queue by the back end;
// any other start then runs the shared bit-per-cycle divider that forms both
// increments, and the back end takes no new item until the divide is done.
// Items wait in a QUEUE_DEPTH entry queue, so input is taken while the back end
// divides or while a result waits in the output register.
// arst_n clears the queue, the sequencer, the active-line flag and out_valid.
`default_nettype none

module dda_line_rasterizer #(
	parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         func,
	input  wire logic signed [COORD_BITS-1:0] x_start,
	input  wire logic signed [COORD_BITS-1:0] y_start,
	input  wire logic signed [COORD_BITS-1:0] x_end,
	input  wire logic signed [COORD_BITS-1:0] y_end,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [COORD_BITS-1:0]      point_x,
	output logic signed [COORD_BITS-1:0]      point_y,
	output logic                              point_valid,
	output logic                              point_last
);

	logic                         q_valid;
	logic                         q_pop;
	logic                         q_func;
	logic signed [COORD_BITS-1:0] q_xa;
	logic signed [COORD_BITS-1:0] q_ya;
	logic [COORD_BITS-1:0]        q_adx;
	logic [COORD_BITS-1:0]        q_ady;
	logic                         q_sx;
	logic                         q_sy;
	logic [COORD_BITS-1:0]        q_steps;

	dda_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.x_start  (x_start),
		.y_start  (y_start),
		.x_end    (x_end),
		.y_end    (y_end),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_func   (q_func),
		.q_xa     (q_xa),
		.q_ya     (q_ya),
		.q_adx    (q_adx),
		.q_ady    (q_ady),
		.q_sx     (q_sx),
		.q_sy     (q_sy),
		.q_steps  (q_steps)
	);

	dda_back #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.q_func      (q_func),
		.q_xa        (q_xa),
		.q_ya        (q_ya),
		.q_adx       (q_adx),
		.q_ady       (q_ady),
		.q_sx        (q_sx),
		.q_sy        (q_sy),
		.q_steps     (q_steps),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_valid (point_valid),
		.point_last  (point_last)
	);

endmodule

`default_nettype wire

### rtl/dda_checker.sv
`default_nettype none

module dda_checker #(
	parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         in_valid,
	input wire logic                         in_ready,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic signed [COORD_BITS-1:0] point_x,
	input wire logic signed [COORD_BITS-1:0] point_y,
	input wire logic                         point_valid,
	input wire logic                         point_last
);

	localparam int MAXO = dda_pkg::QUEUE_DEPTH + 1;
	localparam int OW   = $clog2(MAXO + 2);

	logic          in_xfer;
	logic          out_xfer;
	logic [OW-1:0] pending_q;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;

	// items taken in but not yet transferred out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			case ({in_xfer, out_xfer})
				2'b10:   pending_q <= pending_q + 1'b1;
				2'b01:   pending_q <= pending_q - 1'b1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
			&& $stable(point_valid) && $stable(point_last))
		else $error("result changed while stalled");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !point_valid |-> point_x == '0 && point_y == '0 && !point_last)
		else $error("no-line result carries nonzero fields");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result with no pending item");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= OW'(MAXO))
		else $error("more items in flight than storage holds");

endmodule

bind dda_line_rasterizer dda_checker #(.COORD_BITS(COORD_BITS)) u_dda_checker (.*);

`default_nettype wire

### tb/testbench.sv
`default_nettype none

module testbench;

	localparam int CW      = dda_pkg::COORD_BITS_DEF;
	localparam int FW      = dda_pkg::FRAC_BITS_DEF;
	localparam int ACC_W   = CW + FW + 1;
	localparam int INC_W   = FW + 2;
	localparam int STEPS_W = CW + 1;
	localparam longint HALF_Q = longint'(1) << (FW - 1);
	localparam int ITEM_TARGET = 750;

	typedef logic signed [CW-1:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   valid;
		logic   last;
	} point_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_ready;
	logic   func = dda_pkg::FUNC_START;
	coord_t x_start = '0;
	coord_t y_start = '0;
	coord_t x_end = '0;
	coord_t y_end = '0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	coord_t point_x;
	coord_t point_y;
	logic   point_valid;
	logic   point_last;

	// line tracker state, advanced on each accepted input transfer
	logic signed [ACC_W-1:0] line_x_acc = '0;
	logic signed [ACC_W-1:0] line_y_acc = '0;
	logic signed [INC_W-1:0] line_x_inc = '0;
	logic signed [INC_W-1:0] line_y_inc = '0;
	logic [STEPS_W-1:0]      line_steps_left = '0;
	logic                    line_active = 1'b0;

	point_t pending_points[$];
	int     mismatch_count = 0;
	int     items_accepted = 0;
	bit     steady = 1'b0;

	dda_line_rasterizer #(
		.COORD_BITS(CW),
		.FRAC_BITS(FW)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.x_start(x_start),
		.y_start(y_start),
		.x_end(x_end),
		.y_end(y_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.point_x(point_x),
		.point_y(point_y),
		.point_valid(point_valid),
		.point_last(point_last)
	);

	always #5 clk = ~clk;

	// delta / span in fixed point, truncated toward zero
	function automatic longint slope_q(longint delta, longint span);
		longint mag;
		mag = ((delta < 0 ? -delta : delta) <<< FW) / span;
		return delta < 0 ? -mag : mag;
	endfunction

	// +0.5, then truncate toward zero
	function automatic longint round_q(longint acc);
		longint v;
		v = acc + HALF_Q;
		if (v >= 0)
			return v >>> FW;
		return -((-v) >>> FW);
	endfunction

	function automatic point_t trace_point(logic f, coord_t xs, coord_t ys,
			coord_t xe, coord_t ye);
		longint dx, dy, adx, ady, span;
		point_t p;
		p = '0;
		if (f == dda_pkg::FUNC_START) begin
			dx = longint'(xe) - longint'(xs);
			dy = longint'(ye) - longint'(ys);
			adx = dx < 0 ? -dx : dx;
			ady = dy < 0 ? -dy : dy;
			span = adx > ady ? adx : ady;
			line_x_acc = ACC_W'(longint'(xs) <<< FW);
			line_y_acc = ACC_W'(longint'(ys) <<< FW);
			p.x = xs;
			p.y = ys;
			p.valid = 1'b1;
			if (span == 0) begin
				line_x_inc = '0;
				line_y_inc = '0;
				line_steps_left = '0;
				line_active = 1'b0;
				p.last = 1'b1;
			end else begin
				line_x_inc = INC_W'(slope_q(dx, span));
				line_y_inc = INC_W'(slope_q(dy, span));
				line_steps_left = STEPS_W'(span);
				line_active = 1'b1;
			end
		end else if (line_active) begin
			line_x_acc = ACC_W'(longint'(line_x_acc) + longint'(line_x_inc));
			line_y_acc = ACC_W'(longint'(line_y_acc) + longint'(line_y_inc));
			line_steps_left = line_steps_left - 1'b1;
			if (line_steps_left == 0)
				line_active = 1'b0;
			p.x = coord_t'(round_q(longint'(line_x_acc)));
			p.y = coord_t'(round_q(longint'(line_y_acc)));
			p.valid = 1'b1;
			p.last = (line_steps_left == 0);
		end
		return p;
	endfunction

	task automatic send_item(input logic f, input coord_t xs, input coord_t ys,
			input coord_t xe, input coord_t ye);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		x_start <= xs;
		y_start <= ys;
		x_end <= xe;
		y_end <= ye;
		do @(posedge clk); while (in_ready !== 1'b1);
		pending_points.push_back(trace_point(f, xs, ys, xe, ye));
		items_accepted++;
	endtask

	task automatic send_next();
		send_item(dda_pkg::FUNC_NEXT, coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), coord_t'($urandom));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
	endtask

	function automatic coord_t clamp_coord(int v);
		if (v < -(1 << (CW - 1)))
			return coord_t'(-(1 << (CW - 1)));
		if (v > (1 << (CW - 1)) - 1)
			return coord_t'((1 << (CW - 1)) - 1);
		return coord_t'(v);
	endfunction

	// checker: one result transfer per iteration
	initial begin
		int stall;
		point_t want;
		forever begin
			stall = steady ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (pending_points.size() == 0) begin
				$error("result transfer with nothing pending: x=%0d y=%0d", point_x, point_y);
				mismatch_count++;
			end else begin
				want = pending_points.pop_front();
				if (point_x !== want.x) begin
					$error("point_x: expected %0d, got %0d", want.x, point_x);
					mismatch_count++;
				end
				if (point_y !== want.y) begin
					$error("point_y: expected %0d, got %0d", want.y, point_y);
					mismatch_count++;
				end
				if (point_valid !== want.valid) begin
					$error("point_valid: expected %0d, got %0d", want.valid, point_valid);
					mismatch_count++;
				end
				if (point_last !== want.last) begin
					$error("point_last: expected %0d, got %0d", want.last, point_last);
					mismatch_count++;
				end
			end
		end
	end

	task automatic test_idle_next();
		send_next();
		send_next();
	endtask

	task automatic test_zero_length();
		send_item(dda_pkg::FUNC_START, 11'sd5, -11'sd7, 11'sd5, -11'sd7);
		send_next();
		send_item(dda_pkg::FUNC_START, -11'sd1024, 11'sd1023, -11'sd1024, 11'sd1023);
		send_next();
	endtask

	task automatic test_extremes();
		send_item(dda_pkg::FUNC_START, -11'sd1024, -11'sd1024, 11'sd1023, 11'sd1023);
		repeat (3) send_next();
		// new start abandons the diagonal above
		send_item(dda_pkg::FUNC_START, 11'sd1023, -11'sd1024, -11'sd1024, 11'sd1023);
		repeat (2) send_next();
		// steep short line run to the end, then one past it
		send_item(dda_pkg::FUNC_START, -11'sd1024, 11'sd1023, -11'sd1021, 11'sd1019);
		repeat (5) send_next();
	endtask

	task automatic test_random_lines(input int upto);
		int pick, len;
		coord_t xs, ys;
		while (items_accepted < upto) begin
			pick = $urandom_range(0, 9);
			xs = coord_t'($urandom);
			ys = coord_t'($urandom);
			if (pick == 0) begin
				send_item(logic'($urandom_range(0, 1)), xs, ys,
					coord_t'($urandom), coord_t'($urandom));
			end else if (pick == 1) begin
				send_item(dda_pkg::FUNC_START, xs, ys, coord_t'($urandom),
					coord_t'($urandom));
				repeat ($urandom_range(0, 20)) send_next();
			end else begin
				len = $urandom_range(0, 12);
				send_item(dda_pkg::FUNC_START, xs, ys,
					clamp_coord(int'(xs) + int'($urandom_range(0, 2 * len)) - len),
					clamp_coord(int'(ys) + int'($urandom_range(0, 2 * len)) - len));
				while (line_active && $urandom_range(0, 15) != 0)
					send_next();
				if ($urandom_range(0, 3) == 0)
					send_next();
			end
		end
	endtask

	task automatic test_back_to_back(input int upto);
		steady = 1'b1;
		test_random_lines(upto);
		steady = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_next();
		test_zero_length();
		test_extremes();
		wait_drained();
		test_random_lines(items_accepted + ITEM_TARGET / 2);
		wait_drained();
		test_back_to_back(items_accepted + ITEM_TARGET / 6);
		test_random_lines(items_accepted + ITEM_TARGET / 3);
		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && pending_points.size() == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

	initial begin
		#5000000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
rtl/dda_pkg.sv
rtl/dda_front.sv
rtl/dda_back.sv
rtl/dda_line_rasterizer.sv
rtl/dda_checker.sv
tb/testbench.sv
